// File: design/tscoal_pkg.sv
// Shared codes, widths and defaults for the two-timestep sample coalescer.
package tscoal_pkg;

   // Field widths of the request and response items
   localparam int KindWidth   = 2;
   localparam int CountWidth  = 14;
   localparam int SampleWidth = 32;
   localparam int IdWidth     = 31;
   localparam int ErrorWidth  = 2;

   // Largest count a 14-bit signed header field can carry
   localparam int CountFieldMax = 8191;

   // Default clamp for per-block sample counts
   localparam int MaxBlockSamples = 4096;

   // Header count meaning "block not sampled in this timestep" (-1)
   localparam logic [CountWidth-1:0] CountNone = '1;

   // Request item kinds
   localparam logic [KindWidth-1:0] KIND_HEADER   = 2'd0;
   localparam logic [KindWidth-1:0] KIND_CURRENT  = 2'd1;
   localparam logic [KindWidth-1:0] KIND_PREVIOUS = 2'd2;

   // Response item kinds
   localparam logic [KindWidth-1:0] RESULT_SAMPLE = 2'd0;
   localparam logic [KindWidth-1:0] RESULT_COUNT  = 2'd1;
   localparam logic [KindWidth-1:0] RESULT_ERROR  = 2'd2;

   // Error codes
   localparam logic [ErrorWidth-1:0] ERR_NONE    = 2'd0;
   localparam logic [ErrorWidth-1:0] ERR_NO_DATA = 2'd1;
   localparam logic [ErrorWidth-1:0] ERR_EARLY   = 2'd2;
   localparam logic [ErrorWidth-1:0] ERR_SURPLUS = 2'd3;

endpackage

// File: design/two_timestep_sample_coalescer.sv
// Top level: block-by-block merge of current and previous timestep sample streams.

// Each request is decoded combinationally against the block state (forward-previous
// flag and the two remaining-sample counters) and its response, if any, lands in
// the response register: one item per clock while req_ready is high, response
// valid in the cycle after the request transfer. req_ready drops only while the
// response register holds an untaken item and rsp_ready is low. A header answers with the block's coalesced
// count, or an error when both counts are -1 or the previous block was not
// finished; samples are forwarded or dropped, and a sample beyond its block's
// count answers with a surplus error. Header counts below -1 count as zero and
// counts above MAX_BLOCK_SAMPLES are clamped to it.
module two_timestep_sample_coalescer #(
   parameter int MAX_BLOCK_SAMPLES = tscoal_pkg::MaxBlockSamples
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic signed [13:0] req_current_count,
   input  logic signed [13:0] req_previous_count,
   input  logic [31:0] req_sample_bits,
   input  logic [30:0] req_global_id,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_result_kind,
   output logic [31:0] rsp_out_sample_bits,
   output logic [30:0] rsp_out_global_id,
   output logic signed [13:0] rsp_block_count,
   output logic [1:0]  rsp_error_code
);

   localparam int CntW     = tscoal_pkg::CountWidth;
   localparam int ClampMax = (MAX_BLOCK_SAMPLES > tscoal_pkg::CountFieldMax) ?
                             tscoal_pkg::CountFieldMax : MAX_BLOCK_SAMPLES;
   localparam int LeftW    = $clog2(ClampMax + 1);

   // Clamp a header count that is not -1 into 0..ClampMax
   function automatic logic [LeftW-1:0] clamp_count(input logic signed [CntW-1:0] c);
      logic [LeftW-1:0] res;
      if (c < 0) begin
         res = '0;
      end else if (int'(c) > MAX_BLOCK_SAMPLES) begin
         res = LeftW'(ClampMax);
      end else begin
         res = LeftW'(unsigned'(c));
      end
      return res;
   endfunction

   // Block state
   logic             take_prev_ff, take_prev_in;
   logic [LeftW-1:0] cur_left_ff, cur_left_in;
   logic [LeftW-1:0] prev_left_ff, prev_left_in;

   // Response register
   logic             rsp_valid_ff;
   logic [1:0]       kind_ff, kind_in;
   logic [31:0]      bits_ff, bits_in;
   logic [30:0]      gid_ff, gid_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic [1:0]       err_ff, err_in;

   logic             has_rsp;
   logic             req_xfer;
   logic             cur_none;
   logic             prev_none;
   logic             early;
   logic [LeftW-1:0] new_count;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;

   assign cur_none  = (req_current_count == tscoal_pkg::CountNone);
   assign prev_none = (req_previous_count == tscoal_pkg::CountNone);
   assign early     = (cur_left_ff != '0) || (prev_left_ff != '0);

   // Decode one request against the block state
   always_comb begin
      take_prev_in = take_prev_ff;
      cur_left_in  = cur_left_ff;
      prev_left_in = prev_left_ff;
      has_rsp      = 1'b0;
      kind_in      = tscoal_pkg::RESULT_SAMPLE;
      bits_in      = '0;
      gid_in       = '0;
      count_in     = '0;
      err_in       = tscoal_pkg::ERR_NONE;
      new_count    = '0;
      case (req_kind)
         tscoal_pkg::KIND_HEADER: begin
            has_rsp = 1'b1;
            if (cur_none && prev_none) begin
               // Block sampled in neither timestep: abandon it
               take_prev_in = 1'b0;
               cur_left_in  = '0;
               prev_left_in = '0;
               kind_in      = tscoal_pkg::RESULT_ERROR;
               count_in     = tscoal_pkg::CountNone;
               err_in       = tscoal_pkg::ERR_NO_DATA;
            end else begin
               if (cur_none) begin
                  take_prev_in = 1'b1;
                  cur_left_in  = '0;
                  prev_left_in = clamp_count(req_previous_count);
                  new_count    = prev_left_in;
               end else begin
                  take_prev_in = 1'b0;
                  cur_left_in  = clamp_count(req_current_count);
                  prev_left_in = prev_none ? '0 : clamp_count(req_previous_count);
                  new_count    = cur_left_in;
               end
               count_in = CntW'(new_count);
               if (early) begin
                  kind_in = tscoal_pkg::RESULT_ERROR;
                  err_in  = tscoal_pkg::ERR_EARLY;
               end else begin
                  kind_in = tscoal_pkg::RESULT_COUNT;
               end
            end
         end
         tscoal_pkg::KIND_CURRENT: begin
            has_rsp = 1'b1;
            if (cur_left_ff == '0) begin
               kind_in = tscoal_pkg::RESULT_ERROR;
               err_in  = tscoal_pkg::ERR_SURPLUS;
            end else begin
               cur_left_in = cur_left_ff - 1'b1;
               bits_in     = req_sample_bits;
               gid_in      = req_global_id;
            end
         end
         tscoal_pkg::KIND_PREVIOUS: begin
            if (prev_left_ff == '0) begin
               has_rsp = 1'b1;
               kind_in = tscoal_pkg::RESULT_ERROR;
               err_in  = tscoal_pkg::ERR_SURPLUS;
            end else begin
               // Previous samples of a current-sampled block are dropped
               prev_left_in = prev_left_ff - 1'b1;
               has_rsp      = take_prev_ff;
               bits_in      = req_sample_bits;
               gid_in       = req_global_id;
            end
         end
         default: begin
            has_rsp = 1'b0;
         end
      endcase
   end

   // Block state update on request transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         take_prev_ff <= 1'b0;
         cur_left_ff  <= '0;
         prev_left_ff <= '0;
      end else if (req_xfer) begin
         take_prev_ff <= take_prev_in;
         cur_left_ff  <= cur_left_in;
         prev_left_ff <= prev_left_in;
      end
   end

   // Response valid: load on a producing transfer, clear when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_xfer && has_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (req_xfer && has_rsp) begin
         kind_ff  <= kind_in;
         bits_ff  <= bits_in;
         gid_ff   <= gid_in;
         count_ff <= count_in;
         err_ff   <= err_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_kind     = kind_ff;
   assign rsp_out_sample_bits = bits_ff;
   assign rsp_out_global_id   = gid_ff;
   assign rsp_block_count     = signed'(count_ff);
   assign rsp_error_code      = err_ff;

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the two-timestep sample coalescer.
`timescale 1ns / 1ps

module tb_top;

   // One response item as the block presents it
   typedef struct {
      logic [1:0]         kind;
      logic [31:0]        bits;
      logic [30:0]        gid;
      logic signed [13:0] count;
      logic [1:0]         err;
   } coal_result_type;

   // Request kind with no meaning; the block ignores it
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset;

   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_kind;
   logic signed [13:0] req_current_count;
   logic signed [13:0] req_previous_count;
   logic [31:0]        req_sample_bits;
   logic [30:0]        req_global_id;

   logic               rsp_valid;
   logic               rsp_ready;
   logic [1:0]         rsp_result_kind;
   logic [31:0]        rsp_out_sample_bits;
   logic [30:0]        rsp_out_global_id;
   logic signed [13:0] rsp_block_count;
   logic [1:0]         rsp_error_code;

   // Predicted block state
   logic        take_prev;
   logic [12:0] cur_left;
   logic [12:0] prev_left;

   coal_result_type coalesced_q[$];
   int mismatch_count = 0;
   int items_sent = 0;
   logic idling_on = 1'b1;

   two_timestep_sample_coalescer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_current_count  (req_current_count),
      .req_previous_count (req_previous_count),
      .req_sample_bits    (req_sample_bits),
      .req_global_id      (req_global_id),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_out_sample_bits(rsp_out_sample_bits),
      .rsp_out_global_id  (rsp_out_global_id),
      .rsp_block_count    (rsp_block_count),
      .rsp_error_code     (rsp_error_code)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Header count to samples expected: below -1 is zero, above the cap is the cap
   function automatic logic [12:0] clamp_count(input logic signed [13:0] c);
      if (c < 0)
         return 13'd0;
      if (c > tscoal_pkg::MaxBlockSamples)
         return 13'(tscoal_pkg::MaxBlockSamples);
      return c[12:0];
   endfunction

   // Append one predicted response
   function automatic void queue_result(input coal_result_type r);
      coalesced_q.insert(coalesced_q.size(), r);
   endfunction

   // Advance the predicted state by one accepted item and queue its response
   task automatic coalesce_item(input logic [1:0] kind, input logic signed [13:0] cc,
                                input logic signed [13:0] pc, input logic [31:0] bits,
                                input logic [30:0] gid);
      coal_result_type r;
      logic early;
      logic [12:0] n;
      r.kind  = tscoal_pkg::RESULT_ERROR;
      r.bits  = '0;
      r.gid   = '0;
      r.count = '0;
      r.err   = tscoal_pkg::ERR_SURPLUS;
      early = (cur_left != 0) || (prev_left != 0);
      case (kind)
         tscoal_pkg::KIND_HEADER: begin
            if (cc == tscoal_pkg::CountNone && pc == tscoal_pkg::CountNone) begin
               // nothing sampled in either timestep: abandon the block
               take_prev = 1'b0;
               cur_left  = '0;
               prev_left = '0;
               r.count   = tscoal_pkg::CountNone;
               r.err     = tscoal_pkg::ERR_NO_DATA;
            end else begin
               if (cc == tscoal_pkg::CountNone) begin
                  take_prev = 1'b1;
                  cur_left  = '0;
                  prev_left = clamp_count(pc);
                  n = prev_left;
               end else begin
                  take_prev = 1'b0;
                  cur_left  = clamp_count(cc);
                  prev_left = clamp_count(pc);
                  n = cur_left;
               end
               r.count = {1'b0, n};
               r.kind  = early ? tscoal_pkg::RESULT_ERROR : tscoal_pkg::RESULT_COUNT;
               r.err   = early ? tscoal_pkg::ERR_EARLY : tscoal_pkg::ERR_NONE;
            end
            queue_result(r);
         end
         tscoal_pkg::KIND_CURRENT: begin
            if (cur_left != 0) begin
               cur_left = cur_left - 13'd1;
               r.kind = tscoal_pkg::RESULT_SAMPLE;
               r.bits = bits;
               r.gid  = gid;
               r.err  = tscoal_pkg::ERR_NONE;
            end
            queue_result(r);
         end
         tscoal_pkg::KIND_PREVIOUS: begin
            if (prev_left == 0) begin
               queue_result(r);
            end else begin
               prev_left = prev_left - 13'd1;
               // dropped unless the block takes the previous timestep
               if (take_prev) begin
                  r.kind = tscoal_pkg::RESULT_SAMPLE;
                  r.bits = bits;
                  r.gid  = gid;
                  r.err  = tscoal_pkg::ERR_NONE;
                  queue_result(r);
               end
            end
         end
         default: ;
      endcase
   endtask

   // Drive one item at the falling edge and hold it until the transfer
   task automatic send_item(input logic [1:0] kind, input logic signed [13:0] cc,
                            input logic signed [13:0] pc, input logic [31:0] bits,
                            input logic [30:0] gid);
      @(negedge clock);
      while (idling_on && $urandom_range(0, 99) < 25) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_kind           <= kind;
      req_current_count  <= cc;
      req_previous_count <= pc;
      req_sample_bits    <= bits;
      req_global_id      <= gid;
      do @(posedge clock); while (!req_ready);
      coalesce_item(kind, cc, pc, bits, gid);
      if (kind != KIND_UNUSED)
         items_sent++;
   endtask

   task automatic send_header(input logic signed [13:0] cc, input logic signed [13:0] pc);
      send_item(tscoal_pkg::KIND_HEADER, cc, pc, $urandom, 31'($urandom));
   endtask

   task automatic send_sample(input logic [1:0] kind);
      send_item(kind, 14'($urandom), 14'($urandom), $urandom, 31'($urandom));
   endtask

   // Mostly -1 or small counts; a few near the cap
   function automatic logic signed [13:0] pick_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 20)
         return tscoal_pkg::CountNone;
      if (r < 85)
         return 14'($urandom_range(0, 6));
      if (r < 98)
         return 14'($urandom_range(7, 40));
      return 14'($urandom_range(4090, 4100));
   endfunction

   // Blocks of a header, its current samples, then its previous samples
   task automatic test_forwarding();
      send_header(14'sd2, 14'sd1);
      send_item(tscoal_pkg::KIND_CURRENT, '0, '0, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
      send_item(tscoal_pkg::KIND_CURRENT, '1, '1, 32'h0, 31'h0);
      send_sample(tscoal_pkg::KIND_PREVIOUS);
      send_header(tscoal_pkg::CountNone, 14'sd2);
      send_item(tscoal_pkg::KIND_PREVIOUS, '0, '0, 32'h8000_0000, 31'h4000_0000);
      send_sample(tscoal_pkg::KIND_PREVIOUS);
      send_header(14'sd0, tscoal_pkg::CountNone);
   endtask

   // No-data header, surplus samples, early header, unknown kind
   task automatic test_error_cases();
      send_sample(tscoal_pkg::KIND_PREVIOUS);
      send_sample(tscoal_pkg::KIND_CURRENT);
      send_header(tscoal_pkg::CountNone, tscoal_pkg::CountNone);
      send_item(KIND_UNUSED, '1, '1, $urandom, 31'($urandom));
      send_header(14'sd3, 14'sd2);
      send_sample(tscoal_pkg::KIND_CURRENT);
      send_header(tscoal_pkg::CountNone, 14'sd1);
      send_header(14'sd1, 14'sd5);
      send_header(tscoal_pkg::CountNone, tscoal_pkg::CountNone);
   endtask

   // Counts below -1 and above the cap
   task automatic test_count_clamp();
      send_header(14'sh1FFF, -14'sd8192);
      send_header(-14'sd2, 14'sd5);
      send_header(14'sd4096, 14'sd4097);
      send_header(tscoal_pkg::CountNone, 14'sh1FFF);
      send_header(tscoal_pkg::CountNone, -14'sd8192);
      send_header(14'sd4097, tscoal_pkg::CountNone);
      send_header(tscoal_pkg::CountNone, tscoal_pkg::CountNone);
   endtask

   // Mostly well-formed blocks with random content, some broken ones and noise
   task automatic test_random_blocks(input int n_items);
      int stop_at;
      int roll;
      int n_cur;
      int n_prev;
      int k;
      logic signed [13:0] cc;
      logic signed [13:0] pc;
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) begin
         roll = $urandom_range(0, 99);
         if (roll < 88) begin
            cc = pick_count();
            pc = pick_count();
            n_cur  = int'(clamp_count(cc));
            n_prev = int'(clamp_count(pc));
            send_header(cc, pc);
            // well-formed unless it is too long or chosen to be broken; those get 0 to 10 samples
            k = (roll < 82 && n_cur + n_prev <= 64) ? n_cur + n_prev
                : $urandom_range(0, 10);
            for (int i = 0; i < k; i++)
               send_sample(i < n_cur ? tscoal_pkg::KIND_CURRENT : tscoal_pkg::KIND_PREVIOUS);
         end else if (roll < 94) begin
            send_sample($urandom_range(0, 1) ? tscoal_pkg::KIND_CURRENT
                                             : tscoal_pkg::KIND_PREVIOUS);
         end else begin
            send_item(2'($urandom_range(0, 3)), 14'($urandom), 14'($urandom), $urandom,
                      31'($urandom));
         end
      end
   endtask

   // Random traffic with neither side ever idling
   task automatic test_full_rate(input int n_items);
      idling_on = 1'b0;
      test_random_blocks(n_items);
      idling_on = 1'b1;
   endtask

   // Receiver stalls
   always @(negedge clock)
      rsp_ready <= !idling_on || ($urandom_range(0, 99) >= 25);

   // Compare each response transfer with the oldest prediction
   always @(posedge clock) begin
      coal_result_type got;
      coal_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.kind  = rsp_result_kind;
         got.bits  = rsp_out_sample_bits;
         got.gid   = rsp_out_global_id;
         got.count = rsp_block_count;
         got.err   = rsp_error_code;
         if (coalesced_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: unexpected response kind=%0d bits=%h gid=%h count=%0d err=%0d",
                        $time, got.kind, got.bits, got.gid, got.count, got.err);
         end else begin
            want = coalesced_q.pop_front();
            if (got.kind !== want.kind || got.bits !== want.bits || got.gid !== want.gid ||
                got.count !== want.count || got.err !== want.err) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $write("%0t: mismatch exp kind=%0d bits=%h gid=%h count=%0d err=%0d",
                         $time, want.kind, want.bits, want.gid, want.count, want.err);
                  $display(" got kind=%0d bits=%h gid=%h count=%0d err=%0d",
                           got.kind, got.bits, got.gid, got.count, got.err);
               end
            end
         end
      end
   end

   initial begin
      int waited;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_kind           = tscoal_pkg::KIND_HEADER;
      req_current_count  = '0;
      req_previous_count = '0;
      req_sample_bits    = '0;
      req_global_id      = '0;
      take_prev          = 1'b0;
      cur_left           = '0;
      prev_left          = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_forwarding();
      test_error_cases();
      test_count_clamp();
      test_random_blocks(400);
      test_full_rate(200);
      test_random_blocks(400);

      @(negedge clock);
      req_valid <= 1'b0;

      // drain, then wait for any stray response
      waited = 0;
      while (coalesced_q.size() != 0 && waited < 10000) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);
      if (coalesced_q.size() != 0)
         $display("%0d predicted responses never arrived", coalesced_q.size());

      if (mismatch_count == 0 && coalesced_q.size() == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

   // Hang guard
   initial begin
      #3_000_000;
      $display("tb_top: done, errors");
      $finish;
   end

endmodule
